### src/slq_pkg.sv
// shared types and codes for the sorted list queue
`default_nettype none

package slq_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_W    = 32;
    localparam int TAG_W    = 16;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP_HEAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_TAIL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0]        tag_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        key_t             key;
        tag_t             tag;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                removed_valid;
        key_t                removed_key;
        tag_t                removed_tag;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_item_t;

    // handed from a cell to its right neighbor
    typedef struct packed {
        logic occ;
        logic shift;
        key_t key;
        tag_t tag;
    } link_t;

    // handed from a cell to its left neighbor
    typedef struct packed {
        logic occ;
        key_t key;
        tag_t tag;
    } entry_t;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop_head;
        logic pop_tail;
        logic tail_case;
        key_t key;
        tag_t tag;
    } ctrl_t;

endpackage

`default_nettype wire

### src/slq_cell.sv
// one slot of the sorted list: holds an entry and moves it to a neighbor
`default_nettype none

module slq_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire slq_pkg::ctrl_t  ctrl,
    input  wire slq_pkg::link_t  left,
    output slq_pkg::link_t       right_out,
    input  wire slq_pkg::entry_t from_right,
    output slq_pkg::entry_t      to_left,
    output logic                 gt
);

    logic          occ_reg;
    logic          occ_next;
    slq_pkg::key_t key_reg;
    slq_pkg::key_t key_next;
    slq_pkg::tag_t tag_reg;
    slq_pkg::tag_t tag_next;
    logic          ge;
    logic          shift;
    logic          ins_here;

    assign gt = occ_reg && (key_reg > ctrl.key);
    assign ge = occ_reg && (key_reg >= ctrl.key);

    // the first slot keeps an equal key in front of the new one
    assign shift    = !ctrl.tail_case && (FIRST ? gt : ge);
    assign ins_here = (shift || !occ_reg) && left.occ && !left.shift;

    assign right_out = '{occ: occ_reg, shift: shift, key: key_reg, tag: tag_reg};
    assign to_left   = '{occ: occ_reg, key: key_reg, tag: tag_reg};

    always_comb
    begin
        occ_next = occ_reg;
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.ins)
        begin
            occ_next = occ_reg | left.occ;
            if (left.shift)
            begin
                key_next = left.key;
                tag_next = left.tag;
            end
            else if (ins_here)
            begin
                key_next = ctrl.key;
                tag_next = ctrl.tag;
            end
        end
        else if (ctrl.pop_head)
        begin
            occ_next = from_right.occ;
            key_next = from_right.key;
            tag_next = from_right.tag;
        end
        else if (ctrl.pop_tail)
        begin
            occ_next = from_right.occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

### src/sorted_list_insert_pop_ends_unit.sv
// sorted list with ordered insert and removal at either end
// Commands arrive on cmd_valid/cmd_stall/cmd_data: insert (key, tag),
// remove head (smallest key) or remove tail (largest key). Each accepted
// command gives exactly one response on rsp_valid/rsp_stall/rsp_data with a
// status, the removed entry (zero when none) and the entry count afterwards.
// Entries live in a row of cells; on an insert every cell compares the new
// key at once and the cells at and after the slot move one place right, on a
// head removal all move one place left. The list updates in the transfer cycle
// and the response is registered, showing in the next cycle; one command is taken
// every cycle while cmd_stall is low, set by the row's single compare-and-move step.
// A waiting response does not block the next command while rsp_stall is low;
// while the response register is full and rsp_stall is high, cmd_stall is
// raised and the list holds. Reset empties the list and drops any response.
// Insert into a full list and removal from an empty list leave the list as
// is and report that in status.
`default_nettype none

module sorted_list_insert_pop_ends_unit #(
    parameter int DEPTH = slq_pkg::DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire slq_pkg::cmd_item_t cmd_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output slq_pkg::rsp_item_t      rsp_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    slq_pkg::link_t     lnk  [DEPTH+1];
    slq_pkg::entry_t    rlnk [DEPTH+1];
    logic [DEPTH-1:0]   gt_vec;
    logic [DEPTH-1:0]   occ_vec;
    slq_pkg::ctrl_t     ctrl;
    logic               accept;
    logic               full;
    logic               empty;
    slq_pkg::key_t      tail_key;
    slq_pkg::tag_t      tail_tag;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    slq_pkg::rsp_item_t rsp_data_reg;
    slq_pkg::rsp_item_t rsp_data_next;

    assign lnk[0]      = '{occ: 1'b1, shift: 1'b0, key: '0, tag: '0};
    assign rlnk[DEPTH] = '{occ: 1'b0, key: '0, tag: '0};

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            slq_cell #(
                .FIRST (g == 0)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left       (lnk[g]),
                .right_out  (lnk[g+1]),
                .from_right (rlnk[g+1]),
                .to_left    (rlnk[g]),
                .gt         (gt_vec[g])
            );
            assign occ_vec[g] = rlnk[g].occ;
        end
    endgenerate

    assign full      = occ_vec[DEPTH-1];
    assign empty     = !occ_vec[0];
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        ctrl.ins       = accept && (cmd_data.cmd == slq_pkg::CMD_INSERT) && !full;
        ctrl.pop_head  = accept && (cmd_data.cmd == slq_pkg::CMD_POP_HEAD) && !empty;
        ctrl.pop_tail  = accept && (cmd_data.cmd == slq_pkg::CMD_POP_TAIL) && !empty;
        // no held key above the new one: it goes at the back
        ctrl.tail_case = ~|gt_vec;
        ctrl.key       = cmd_data.key;
        ctrl.tag       = cmd_data.tag;
    end

    // last occupied cell, picked out by the edge of the occupancy run
    always_comb
    begin
        tail_key = '0;
        tail_tag = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (occ_vec[i] && !rlnk[i+1].occ)
            begin
                tail_key = tail_key | lnk[i+1].key;
                tail_tag = tail_tag | lnk[i+1].tag;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop_head || ctrl.pop_tail)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        rsp_data_next               = '0;
        rsp_data_next.status        = slq_pkg::ST_DONE;
        rsp_data_next.entry_count   = slq_pkg::COUNT_W'(count_next);
        case (cmd_data.cmd)
            slq_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_data_next.status = slq_pkg::ST_FULL;
                end
            end
            slq_pkg::CMD_POP_HEAD:
            begin
                if (empty)
                begin
                    rsp_data_next.status = slq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_data_next.removed_valid = 1'b1;
                    rsp_data_next.removed_key   = rlnk[0].key;
                    rsp_data_next.removed_tag   = rlnk[0].tag;
                end
            end
            slq_pkg::CMD_POP_TAIL:
            begin
                if (empty)
                begin
                    rsp_data_next.status = slq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp_data_next.removed_valid = 1'b1;
                    rsp_data_next.removed_key   = tail_key;
                    rsp_data_next.removed_tag   = tail_tag;
                end
            end
            default:
            begin
                rsp_data_next.status = slq_pkg::ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef NO_ASSERTIONS
    // occupancy of the row agrees with the count
    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == count_reg)
    else $error("cell occupancy does not match count");

    // occupied cells form one run from the head
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("gap in occupied cells");

    // a removal from a non-empty list takes away one entry
    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg != '0 &&
         (cmd_data.cmd == slq_pkg::CMD_POP_HEAD || cmd_data.cmd == slq_pkg::CMD_POP_TAIL))
        |=> (count_reg == $past(count_reg) - 1'b1))
    else $error("removal did not lower count");
`endif

endmodule

`default_nettype wire
